>>> rtl/bdi_pkg.sv
// Shared field widths and operation codes for the bounded deque block.
package bdi_pkg;

   localparam int MODE_WIDTH  = 3;
   localparam int INDEX_WIDTH = 8;

   localparam logic [MODE_WIDTH-1:0] MODE_PUSH_HEAD = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_PUSH_TAIL = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_HEAD  = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_TAIL  = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_READ      = 3'd4;

endpackage

>>> rtl/bdi_ram.sv
// Generic single-write, single-read memory with a registered read port.
module bdi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bounded_deque_indexed.sv
// Top level of the bounded deque: circular store with head, tail and indexed reads.
//
//   Channel  Direction  Handshake                Payload
//   req      in         req_tvalid/req_tready    mode, entry_data, position_index
//   rsp      out        rsp_tvalid/rsp_tready    count, head, tail, indexed, flags
//
// One beat is accepted per cycle unless stalled; its result passes read and output stages.
// The store is three copies of one memory, one per read address, each with a registered read.
// Reset clears the head pointer, the count and the valid flags; the store is not cleared.
// A stalled result is held in the output register, one more beat waits in the read stage,
// and only then does req_tready fall.
module bounded_deque_indexed #(
   parameter int CAPACITY   = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   // Fields from bit 0 up: mode, entry_data, position_index, zero fill.
   input  logic [(((bdi_pkg::MODE_WIDTH + DATA_WIDTH + bdi_pkg::INDEX_WIDTH) + 7) / 8) * 8 - 1:0]
                req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0 up: entry_count, head_data, tail_data, indexed_data, op_rejected,
   // index_invalid, zero fill.
   output logic [((($clog2(CAPACITY + 1) + 3 * DATA_WIDTH + 2) + 7) / 8) * 8 - 1:0]
                rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = bdi_pkg::INDEX_WIDTH;
   localparam int SW = ((CW > IW) ? CW : IW) + 1;
   localparam int RSP_BITS = CW + 3 * DATA_WIDTH + 2;
   localparam int RSP_TDATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;
   localparam int IDX_LSB = CW + 2 * DATA_WIDTH;
   localparam int INVALID_BIT = CW + 3 * DATA_WIDTH + 1;

   typedef struct packed {
      logic [CW-1:0]         count;
      logic                  empty;
      logic                  rejected;
      logic                  index_invalid;
      logic                  byp_head;
      logic                  byp_tail;
      logic                  byp_idx;
      logic [DATA_WIDTH-1:0] wdata;
   } meta_type;

   function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] sum);
      logic [SW-1:0] diff;
      diff = sum - SW'(CAPACITY);
      if (sum >= SW'(CAPACITY)) begin
         return diff[AW-1:0];
      end
      return sum[AW-1:0];
   endfunction

   logic [bdi_pkg::MODE_WIDTH-1:0] req_mode;
   logic [DATA_WIDTH-1:0]          req_entry;
   logic [IW-1:0]                  req_index;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          s1_valid_ff, s1_valid_in;
   meta_type      s1_meta_ff, s1_meta_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic          accept, s1_move, full, empty;
   logic [AW-1:0] head_dec, head_inc, wr_slot, rd_tail, rd_idx;
   logic          wr_req, rejected;
   logic [DATA_WIDTH-1:0] head_q, tail_q, idx_q, head_val, tail_val, idx_val;

   assign req_mode  = req_tdata[bdi_pkg::MODE_WIDTH-1:0];
   assign req_entry = req_tdata[bdi_pkg::MODE_WIDTH +: DATA_WIDTH];
   assign req_index = req_tdata[bdi_pkg::MODE_WIDTH + DATA_WIDTH +: IW];

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign head_dec = (head_ff == '0) ? AW'(CAPACITY - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == AW'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_slot  = head_dec;
      wr_req   = 1'b0;
      rejected = 1'b0;
      unique case (req_mode)
         bdi_pkg::MODE_PUSH_HEAD: begin
            if (full) begin
               rejected = 1'b1;
            end else begin
               head_in  = head_dec;
               wr_req   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         bdi_pkg::MODE_PUSH_TAIL: begin
            wr_slot = wrap_slot(SW'(head_ff) + SW'(count_ff));
            if (full) begin
               rejected = 1'b1;
            end else begin
               wr_req   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         bdi_pkg::MODE_POP_HEAD: begin
            if (empty) begin
               rejected = 1'b1;
            end else begin
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
            end
         end
         bdi_pkg::MODE_POP_TAIL: begin
            if (empty) begin
               rejected = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_tail = wrap_slot(SW'(head_in) + SW'(count_in) - SW'(1));
   assign rd_idx  = wrap_slot(SW'(head_in) + SW'(req_index));

   always_comb begin
      s1_meta_in.count         = count_in;
      s1_meta_in.empty         = (count_in == '0);
      s1_meta_in.rejected      = rejected;
      s1_meta_in.index_invalid = (SW'(req_index) >= SW'(count_in));
      s1_meta_in.byp_head      = wr_req && (head_in == wr_slot);
      s1_meta_in.byp_tail      = wr_req && (rd_tail == wr_slot);
      s1_meta_in.byp_idx       = wr_req && (rd_idx == wr_slot);
      s1_meta_in.wdata         = req_entry;
   end

   bdi_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_head_ram (
      .clock   (clock),
      .wr_en   (accept && wr_req),
      .wr_addr (wr_slot),
      .wr_data (req_entry),
      .rd_en   (accept),
      .rd_addr (head_in),
      .rd_data (head_q)
   );

   bdi_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_tail_ram (
      .clock   (clock),
      .wr_en   (accept && wr_req),
      .wr_addr (wr_slot),
      .wr_data (req_entry),
      .rd_en   (accept),
      .rd_addr (rd_tail),
      .rd_data (tail_q)
   );

   bdi_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_index_ram (
      .clock   (clock),
      .wr_en   (accept && wr_req),
      .wr_addr (wr_slot),
      .wr_data (req_entry),
      .rd_en   (accept),
      .rd_addr (rd_idx),
      .rd_data (idx_q)
   );

   // A read of the slot written in the same beat takes the new word from the side path.
   assign head_val = s1_meta_ff.empty ? '0 :
                     (s1_meta_ff.byp_head ? s1_meta_ff.wdata : head_q);
   assign tail_val = s1_meta_ff.empty ? '0 :
                     (s1_meta_ff.byp_tail ? s1_meta_ff.wdata : tail_q);
   assign idx_val  = s1_meta_ff.index_invalid ? '0 :
                     (s1_meta_ff.byp_idx ? s1_meta_ff.wdata : idx_q);

   assign rsp_data_in = RSP_TDATA_WIDTH'({s1_meta_ff.index_invalid, s1_meta_ff.rejected,
                                          idx_val, tail_val, head_val, s1_meta_ff.count});

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= s1_meta_in;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("Entry count exceeds capacity.");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      SW'(head_ff) < SW'(CAPACITY))
      else $error("Head pointer is outside the store.");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && empty && (req_mode == bdi_pkg::MODE_POP_HEAD ||
                           req_mode == bdi_pkg::MODE_POP_TAIL))
      |=> (count_ff == '0) && $stable(head_ff))
      else $error("A remove from an empty list changed the state.");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("Input taken while both result stages are full.");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[INVALID_BIT]) |-> (rsp_data_ff[IDX_LSB +: DATA_WIDTH] == '0))
      else $error("Indexed data is not zero for an invalid index.");
`endif

endmodule
